[src/ule_pkg.sv]
// Package of the UART line editor: payload structs, operation codes and the
// character constants shared by the front end and the back end.
// No dependencies.
package ule_pkg;

  // Input modes.
  localparam logic [1:0] MODE_BYTE    = 2'd0;
  localparam logic [1:0] MODE_READ    = 2'd1;
  localparam logic [1:0] MODE_RELEASE = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_ECHO    = 2'd0;
  localparam logic [1:0] KIND_READ    = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;

  // Characters.
  localparam logic [7:0] CHR_CR = 8'h0D;
  localparam logic [7:0] CHR_LF = 8'h0A;
  localparam logic [7:0] CHR_BS = 8'h08;
  localparam logic [7:0] CHR_SP = 8'h20;

  localparam int unsigned LEN_W = 9;
  localparam logic [LEN_W-1:0] LEN_MAX = 9'h1FF;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] rx_byte;
    logic [7:0] read_index;
  } in_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       data;
    logic             last;
    logic             line_ready;
    logic [LEN_W-1:0] line_length;
  } out_t;

  typedef enum logic [2:0] {
    OP_ECHO,     // echo one byte
    OP_CRLF,     // echo CR then LF
    OP_RUBOUT,   // echo BS, space, BS
    OP_READ,     // return a stored byte
    OP_RELEASE   // release acknowledge
  } op_t;

  // One classified request handed from the front end to the back end.
  typedef struct packed {
    op_t              op;
    logic [7:0]       data;
    logic             wr_en;
    logic             rd_hit;
    logic             line_ready;
    logic [LEN_W-1:0] line_length;
  } cmd_t;

endpackage

[src/ule_front.sv]
// Front end of the UART line editor: accepts requests, keeps the line count
// and pending flag, and classifies each request into a command for the queue.
// Depends on ule_pkg.
module ule_front import ule_pkg::*; #(
  parameter int unsigned LINE_BYTES = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  in_t                           in_data,
  input  logic                          q_full,
  output logic                          q_push,
  output cmd_t                          q_cmd,
  output logic [$clog2(LINE_BYTES)-1:0] q_addr
);

  localparam int unsigned AW = $clog2(LINE_BYTES);
  localparam int unsigned CW = $clog2(LINE_BYTES + 1);

  logic [CW-1:0]   count_r, count_nxt;
  logic            pend_r, pend_nxt;
  logic            accept;
  logic            term, bs, had_bytes, line_full;
  logic [CW+7:0]   idx_cmp, cnt_cmp;
  logic [CW+8:0]   len_ext;
  logic            rd_hit;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign term      = (in_data.rx_byte == CHR_CR) || (in_data.rx_byte == CHR_LF);
  assign bs        = (in_data.rx_byte == CHR_BS);
  assign had_bytes = (count_r != '0);
  assign line_full = (count_r == CW'(LINE_BYTES));
  assign idx_cmp   = {{CW{1'b0}}, in_data.read_index};
  assign cnt_cmp   = {8'b0, count_r};
  assign rd_hit    = (idx_cmp < cnt_cmp);
  assign len_ext   = {{LEN_W{1'b0}}, count_nxt};

  always_comb begin
    count_nxt    = count_r;
    pend_nxt     = pend_r;
    q_push       = 1'b0;
    q_cmd.op     = OP_ECHO;
    q_cmd.data   = in_data.rx_byte;
    q_cmd.wr_en  = 1'b0;
    q_cmd.rd_hit = rd_hit;
    q_addr       = count_r[AW-1:0];
    unique case (in_data.mode)
      MODE_BYTE: begin
        if (term) begin
          q_push   = accept;
          q_cmd.op = OP_CRLF;
          if (!pend_r) begin
            pend_nxt = 1'b1;
          end
        end else if (bs) begin
          q_push   = accept && had_bytes;
          q_cmd.op = OP_RUBOUT;
          if (!pend_r && had_bytes) begin
            count_nxt = count_r - CW'(1);
          end
        end else begin
          q_push = accept;
          if (!pend_r && !line_full) begin
            q_cmd.wr_en = 1'b1;
            count_nxt   = count_r + CW'(1);
          end
        end
      end
      MODE_READ: begin
        q_push   = accept;
        q_cmd.op = OP_READ;
        q_addr   = AW'(in_data.read_index);
      end
      MODE_RELEASE: begin
        q_push   = accept;
        q_cmd.op = OP_RELEASE;
        if (pend_r) begin
          count_nxt = '0;
          pend_nxt  = 1'b0;
        end
      end
      default: ;
    endcase
    q_cmd.line_ready  = pend_nxt;
    q_cmd.line_length = (len_ext > (CW+9)'(LEN_MAX)) ? LEN_MAX : len_ext[LEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pend_r  <= 1'b0;
    end else if (accept) begin
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

[src/ule_fifo.sv]
// Four-entry command queue between the front and back ends of the line editor.
// Standalone; the payload width is a parameter.
module ule_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic             rd_valid,
  output logic [WIDTH-1:0] rd_data
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PW    = $clog2(DEPTH);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [PW:0]      fill_r;

  assign full     = (fill_r == (PW+1)'(DEPTH));
  assign rd_valid = (fill_r != '0);
  assign rd_data  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      if (wr_en && !rd_en) begin
        fill_r <= fill_r + (PW+1)'(1);
      end else if (rd_en && !wr_en) begin
        fill_r <= fill_r - (PW+1)'(1);
      end
    end
  end

endmodule

[src/ule_back.sv]
// Back end of the line editor: owns the line store, executes queued commands
// and issues one result per cycle into the output register while it is free.
// Depends on ule_pkg.
module ule_back import ule_pkg::*; #(
  parameter int unsigned LINE_BYTES = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  cmd_t                          q_cmd,
  input  logic [$clog2(LINE_BYTES)-1:0] q_addr,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output out_t                          out_data
);

  logic [7:0] store_mem [LINE_BYTES];
  logic [7:0] rd_data_r;
  cmd_t       cur_r;
  logic       cur_vld_r;
  logic [1:0] step_r;
  logic [1:0] last_step;
  logic       out_free, emit, done;
  out_t       res;
  out_t       out_r;
  logic       out_vld_r;

  assign out_valid = out_vld_r;
  assign out_data  = out_r;
  assign out_free  = !out_vld_r || out_ready;
  assign emit      = cur_vld_r && out_free;
  assign done      = emit && (step_r == last_step);
  assign q_pop     = q_valid && (!cur_vld_r || done);

  always_comb begin
    last_step       = 2'd0;
    res.kind        = KIND_ECHO;
    res.data        = cur_r.data;
    res.line_ready  = cur_r.line_ready;
    res.line_length = cur_r.line_length;
    unique case (cur_r.op)
      OP_ECHO: ;
      OP_CRLF: begin
        last_step = 2'd1;
        res.data  = (step_r == 2'd0) ? CHR_CR : CHR_LF;
      end
      OP_RUBOUT: begin
        last_step = 2'd2;
        res.data  = (step_r == 2'd1) ? CHR_SP : CHR_BS;
      end
      OP_READ: begin
        res.kind = KIND_READ;
        res.data = cur_r.rd_hit ? rd_data_r : 8'h00;
      end
      OP_RELEASE: begin
        res.kind = KIND_RELEASE;
        res.data = 8'h00;
      end
      default: ;
    endcase
    res.last = (step_r == last_step);
  end

  // The store is written and read when a command is popped, so every read
  // sees all writes queued ahead of it.
  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.wr_en) begin
      store_mem[q_addr] <= q_cmd.data;
    end
    if (q_pop) begin
      rd_data_r <= store_mem[q_addr];
      cur_r     <= q_cmd;
    end
    if (emit) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      step_r    <= 2'd0;
      out_vld_r <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_vld_r <= 1'b1;
        step_r    <= 2'd0;
      end else begin
        if (done) begin
          cur_vld_r <= 1'b0;
        end
        if (emit) begin
          step_r <= step_r + 2'd1;
        end
      end
      if (emit) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

endmodule

[src/uart_line_editor.sv]
// Top level of the UART line editor: front end, command queue and back end.
// Depends on ule_pkg, ule_front, ule_fifo and ule_back.
//
// Usage: each request on the in_ channel is a received UART byte (mode 0),
// a read of a stored byte by index (mode 1) or a release of the pending line
// (mode 2). Results leave on the out_ channel: echo bytes for the transmitter
// (one, CR LF, or BS space BS), read data, or a release acknowledge. Every
// result carries the line_ready flag and line_length as they stand after the
// request that caused it, and last marks the final result of a request.
// A backspace on an empty line and mode 3 produce no result at all.
//
// The front end updates the line count and pending flag as a request is
// accepted and pushes a classified command into a four-entry queue. The back
// end owns the line store and drains the queue, issuing one result per cycle
// into the output register while the receiver does not stall it. The first
// result of a request passes through the queue, the command register and the
// output register; the back end pops the next command as it issues the last
// result of the current one. The front end keeps accepting one request per
// cycle as long as the queue has room.
//
// When the receiver stalls, the output register holds its result, the back
// end stops, the queue fills and in_ready falls once four commands wait.
// Reset (synchronous, rst_n low) empties the line, clears the pending flag and
// flushes the queue and output register; the line store needs no clearing.
module uart_line_editor import ule_pkg::*; #(
  parameter int unsigned LINE_BYTES = 256
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int unsigned AW = $clog2(LINE_BYTES);
  localparam int unsigned QW = $bits(cmd_t) + AW;

  logic          q_push, q_full, q_pop, q_valid;
  cmd_t          push_cmd, head_cmd;
  logic [AW-1:0] push_addr, head_addr;
  logic [QW-1:0] head_word;

  ule_front #(.LINE_BYTES(LINE_BYTES)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd),
    .q_addr   (push_addr)
  );

  ule_fifo #(.WIDTH(QW)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_push),
    .wr_data  ({push_cmd, push_addr}),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_data  (head_word)
  );

  assign head_cmd  = head_word[QW-1:AW];
  assign head_addr = head_word[AW-1:0];

  ule_back #(.LINE_BYTES(LINE_BYTES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (head_cmd),
    .q_addr    (head_addr),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[src/ule_checker.sv]
// Port-level checker for the UART line editor, bound to the top level.
// Depends on ule_pkg.
module ule_checker import ule_pkg::*; #(
  parameter int unsigned LINE_BYTES = 256
) (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Reads and release acknowledges are single results.
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == KIND_READ || out_data.kind == KIND_RELEASE)
    |-> out_data.last)
    else $error("read or release result not marked last");

  // After a release no line is pending.
  a_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_RELEASE |-> !out_data.line_ready)
    else $error("line still pending after release");

  // The line never grows past its capacity.
  a_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_data.line_length) <= LINE_BYTES)
    else $error("line length beyond capacity");

  // A CR echo that is not last is followed at once by the LF echo.
  a_crlf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.kind == KIND_ECHO &&
    out_data.data == CHR_CR && !out_data.last
    |=> out_valid && out_data.data == CHR_LF && out_data.last)
    else $error("CR echo not followed by LF");

endmodule

bind uart_line_editor ule_checker #(.LINE_BYTES(LINE_BYTES)) u_ule_checker (.*);
